// ===== src/sccd_pkg.sv =====
`timescale 1ns / 1ps

package sccd_pkg;

  // Line length limit and the cap the 8-bit count saturates at
  localparam int LINE_MAX = 255;
  localparam logic [7:0] LINE_CAP = 8'((LINE_MAX > 255) ? 255 : LINE_MAX);

  // Set-1 codes with special handling
  localparam logic [7:0] RELEASE_BIT  = 8'h80;
  localparam logic [6:0] CODE_LSHIFT  = 7'h2A;
  localparam logic [6:0] CODE_RSHIFT  = 7'h36;
  localparam logic [6:0] CODE_BKSP    = 7'h0E;
  localparam logic [6:0] CODE_ENTER   = 7'h1C;
  localparam logic [6:0] CODE_CAPS    = 7'h3A;
  localparam logic [6:0] CODE_NUM     = 7'h45;
  localparam logic [6:0] CODE_SCROLL  = 7'h46;
  localparam logic [6:0] TABLE_SIZE   = 7'd86;

  // Lock LED bits
  localparam logic [2:0] LED_SCROLL = 3'b001;
  localparam logic [2:0] LED_NUM    = 3'b010;
  localparam logic [2:0] LED_CAPS   = 3'b100;

  typedef enum logic [2:0] {
    ACT_NONE = 3'd0,
    ACT_CHAR = 3'd1,
    ACT_DEL  = 3'd2,
    ACT_EOL  = 3'd3,
    ACT_LED  = 3'd4
  } action_t;

  typedef struct packed {
    logic [7:0] line_length;
    logic [2:0] led_bits;
    logic [6:0] character;
    action_t    action;
  } result_t;

  // Printable character for a make code; zero where the key prints nothing
  function automatic logic [6:0] key_char(input logic [6:0] code);
    logic [6:0] ch;
    case (code)
      7'h02: ch = 7'h31; // 1
      7'h03: ch = 7'h32; // 2
      7'h04: ch = 7'h33; // 3
      7'h05: ch = 7'h34; // 4
      7'h06: ch = 7'h35; // 5
      7'h07: ch = 7'h36; // 6
      7'h08: ch = 7'h37; // 7
      7'h09: ch = 7'h38; // 8
      7'h0A: ch = 7'h39; // 9
      7'h0B: ch = 7'h30; // 0
      7'h0C: ch = 7'h2D; // -
      7'h0D: ch = 7'h3D; // =
      7'h10: ch = 7'h51; // Q
      7'h11: ch = 7'h57; // W
      7'h12: ch = 7'h45; // E
      7'h13: ch = 7'h52; // R
      7'h14: ch = 7'h54; // T
      7'h15: ch = 7'h59; // Y
      7'h16: ch = 7'h55; // U
      7'h17: ch = 7'h49; // I
      7'h18: ch = 7'h4F; // O
      7'h19: ch = 7'h50; // P
      7'h1A: ch = 7'h5B; // [
      7'h1B: ch = 7'h5D; // ]
      7'h1E: ch = 7'h41; // A
      7'h1F: ch = 7'h53; // S
      7'h20: ch = 7'h44; // D
      7'h21: ch = 7'h46; // F
      7'h22: ch = 7'h47; // G
      7'h23: ch = 7'h48; // H
      7'h24: ch = 7'h4A; // J
      7'h25: ch = 7'h4B; // K
      7'h26: ch = 7'h4C; // L
      7'h27: ch = 7'h3B; // ;
      7'h28: ch = 7'h27; // quote
      7'h29: ch = 7'h60; // backtick
      7'h2B: ch = 7'h5C; // backslash
      7'h2C: ch = 7'h5A; // Z
      7'h2D: ch = 7'h58; // X
      7'h2E: ch = 7'h43; // C
      7'h2F: ch = 7'h56; // V
      7'h30: ch = 7'h42; // B
      7'h31: ch = 7'h4E; // N
      7'h32: ch = 7'h4D; // M
      7'h33: ch = 7'h2C; // ,
      7'h34: ch = 7'h2E; // .
      7'h35: ch = 7'h2F; // /
      7'h37: ch = 7'h2A; // *
      7'h39: ch = 7'h20; // space
      7'h47: ch = 7'h37; // keypad 7
      7'h4A: ch = 7'h2D; // keypad -
      7'h4C: ch = 7'h35; // keypad 5
      7'h4E: ch = 7'h2B; // keypad +
      7'h4F: ch = 7'h31; // keypad 1
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== src/sccd_decode.sv =====
`timescale 1ns / 1ps

module sccd_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [7:0]          scan_byte,
  output sccd_pkg::result_t   result
);

  logic       shift_held;
  logic       shift_held_next;
  logic [2:0] lock_leds;
  logic [2:0] lock_leds_next;
  logic [7:0] line_count;
  logic [7:0] line_count_next;

  logic [6:0] code;
  logic [6:0] tbl_char;
  logic [6:0] ch;
  sccd_pkg::action_t act;
  logic       is_shift;

  assign code     = scan_byte[6:0];
  assign tbl_char = sccd_pkg::key_char(code);
  assign is_shift = (code == sccd_pkg::CODE_LSHIFT) || (code == sccd_pkg::CODE_RSHIFT);

  // Decode one byte against the current key state
  always_comb begin
    shift_held_next = shift_held;
    lock_leds_next  = lock_leds;
    line_count_next = line_count;
    act             = sccd_pkg::ACT_NONE;
    ch              = 7'h00;
    if ((scan_byte & sccd_pkg::RELEASE_BIT) != 8'h00) begin
      if (is_shift) begin
        shift_held_next = 1'b0;
      end
    end else if (code >= sccd_pkg::TABLE_SIZE) begin
      // past the table: ignored
    end else if (is_shift) begin
      shift_held_next = 1'b1;
    end else if (tbl_char == 7'h00) begin
      case (code)
        sccd_pkg::CODE_BKSP: begin
          if (line_count != 8'd0) begin
            line_count_next = line_count - 8'd1;
            act             = sccd_pkg::ACT_DEL;
          end
        end
        sccd_pkg::CODE_ENTER: begin
          line_count_next = 8'd0;
          act             = sccd_pkg::ACT_EOL;
        end
        sccd_pkg::CODE_CAPS: begin
          lock_leds_next = lock_leds ^ sccd_pkg::LED_CAPS;
          act            = sccd_pkg::ACT_LED;
        end
        sccd_pkg::CODE_NUM: begin
          lock_leds_next = lock_leds ^ sccd_pkg::LED_NUM;
          act            = sccd_pkg::ACT_LED;
        end
        sccd_pkg::CODE_SCROLL: begin
          lock_leds_next = lock_leds ^ sccd_pkg::LED_SCROLL;
          act            = sccd_pkg::ACT_LED;
        end
        default: begin
        end
      endcase
    end else begin
      ch = tbl_char;
      // letters go lower case unless exactly one of caps and shift is on
      if ((tbl_char >= 7'h41) && (tbl_char <= 7'h5A) &&
          (((lock_leds & sccd_pkg::LED_CAPS) != 3'b000) == shift_held)) begin
        ch = tbl_char + 7'd32;
      end
      if (line_count < sccd_pkg::LINE_CAP) begin
        line_count_next = line_count + 8'd1;
      end
      act = sccd_pkg::ACT_CHAR;
    end
  end

  // Result reflects state after this byte
  always_comb begin
    result.action      = act;
    result.character   = ch;
    result.led_bits    = lock_leds_next;
    result.line_length = line_count_next;
  end

  // Key state advances once per decoded byte
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held <= 1'b0;
      lock_leds  <= 3'b000;
      line_count <= 8'd0;
    end else if (advance) begin
      shift_held <= shift_held_next;
      lock_leds  <= lock_leds_next;
      line_count <= line_count_next;
    end
  end

`ifndef SYNTH
  a_count_capped: assert property (@(posedge clk) disable iff (rst)
    line_count <= sccd_pkg::LINE_CAP)
    else $error("line count above cap");

  a_enter_clears: assert property (@(posedge clk) disable iff (rst)
    advance && (scan_byte == {1'b0, sccd_pkg::CODE_ENTER}) |=> line_count == 8'd0)
    else $error("enter did not clear line count");

  a_shift_make: assert property (@(posedge clk) disable iff (rst)
    advance && (scan_byte == {1'b0, sccd_pkg::CODE_LSHIFT}) |=> shift_held)
    else $error("shift make did not set shift flag");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(line_count) && $stable(lock_leds) && $stable(shift_held))
    else $error("key state changed without a byte");
`endif

endmodule

// ===== src/scan_code_set1_key_decoder.sv =====
`timescale 1ns / 1ps

// Path from an input beat to its result on the master side: the input register,
// then decode into the result register.
// Throughput: one beat per cycle unless m_axis_tready stalls the result register; the decode is a single table lookup.
// Reset (rst, synchronous): clears both stage valids, the shift flag,
// the lock LEDs and the line count.
module scan_code_set1_key_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] scan_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [2:0] action, [9:3] character,
                                      // [12:10] led_bits, [20:13] line_length
);

  logic              in_full;
  logic [7:0]        in_byte;
  logic              advance;
  sccd_pkg::result_t result;
  sccd_pkg::result_t out_result;

  // Byte moves to the result register whenever that slot is free or draining
  assign advance       = in_full && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_full || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_axis_tready) begin
      in_full <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  sccd_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .scan_byte (in_byte),
    .result    (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  assign m_axis_tdata = {3'b000, out_result.line_length, out_result.led_bits,
                         out_result.character, out_result.action};

`ifndef SYNTH
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> in_full && m_axis_tvalid)
    else $error("input stalled with a free stage");

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_axis_tvalid)
    else $error("decoded beat lost");

  a_action_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_result.action == sccd_pkg::ACT_CHAR) ||
                      (out_result.character == 7'h00))
    else $error("character set on a non-character action");
`endif

endmodule
